@@ rtl/crcdf_pkg.sv @@
// ----------------------------------------------------------------------------
// crcdf_pkg
// Shared types, codes and the byte-wide CRC-16 update for the packet deframer.
// ----------------------------------------------------------------------------
package crcdf_pkg;

	// Request kinds carried on the input tuser.
	localparam logic [1:0] REQ_ARM  = 2'd0;
	localparam logic [1:0] REQ_BYTE = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	// Result kinds carried on the output tuser.
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	// Stage codes reported in final_stage.
	localparam logic [2:0] STG_GOOD   = 3'd0;
	localparam logic [2:0] STG_HEADER = 3'd1;
	localparam logic [2:0] STG_LENGTH = 3'd2;
	localparam logic [2:0] STG_OPCODE = 3'd3;
	localparam logic [2:0] STG_STATUS = 3'd4;
	localparam logic [2:0] STG_DATA   = 3'd5;
	localparam logic [2:0] STG_CRC    = 3'd6;

	localparam logic [15:0] TIMEOUT_RESET = 16'd500;
	localparam logic [7:0]  HEADER_BYTE   = 8'hFF;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;

	// Register index of the configuration port.
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_HEADER = 7'b0000010,
		ST_LENGTH = 7'b0000100,
		ST_OPCODE = 7'b0001000,
		ST_STATUS = 7'b0010000,
		ST_DATA   = 7'b0100000,
		ST_CRC    = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        out_kind;
		logic [7:0]  payload_byte;
		logic [7:0]  payload_index;
		logic [2:0]  final_stage;
		logic [7:0]  frame_length;
		logic [7:0]  frame_opcode;
		logic [15:0] status_word;
		logic [15:0] received_crc;
		logic [15:0] computed_crc;
	} result_t;

	function automatic logic [2:0] stage_code(input state_t st);
		logic [2:0] code;
		unique case (st)
			ST_IDLE:   code = STG_GOOD;
			ST_HEADER: code = STG_HEADER;
			ST_LENGTH: code = STG_LENGTH;
			ST_OPCODE: code = STG_OPCODE;
			ST_STATUS: code = STG_STATUS;
			ST_DATA:   code = STG_DATA;
			ST_CRC:    code = STG_CRC;
			default:   code = STG_GOOD;
		endcase
		return code;
	endfunction

	// Data bits enter the low end MSB first; the polynomial is folded in
	// whenever a one leaves bit 15.
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [7:0] data);
		logic [15:0] crc;
		logic        carry;
		crc = crc_in;
		for (int k = 0; k < 8; k++) begin
			carry = crc[15];
			crc = {crc[14:0], data[7-k]};
			if (carry) begin
				crc = crc ^ CRC_POLY;
			end
		end
		return crc;
	endfunction

endpackage

@@ rtl/crcdf_cfg.sv @@
// ----------------------------------------------------------------------------
// crcdf_cfg
// Configuration register file: holds the reply timeout behind a small APB port.
// ----------------------------------------------------------------------------
module crcdf_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [15:0] timeout_ticks
);

	logic [15:0] timeout_q;
	logic        hit_timeout;

	// Only word addresses are decoded; the two low address bits are ignored.
	assign hit_timeout = (paddr[2] == crcdf_pkg::REG_TIMEOUT);
	assign pready      = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= crcdf_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready && hit_timeout) begin
			timeout_q <= pwdata[15:0];
		end
	end

	assign prdata        = hit_timeout ? {16'd0, timeout_q} : 32'd0;
	assign timeout_ticks = timeout_q;

endmodule

@@ rtl/crcdf_core.sv @@
// ----------------------------------------------------------------------------
// crcdf_core
// Frame state machine: holds the frame state, updates it for one request when
// told to and computes the result that request produces.
// ----------------------------------------------------------------------------
module crcdf_core (
	input  logic                clk,
	input  logic                arst_n,
	input  crcdf_pkg::item_t    item,
	input  logic                take,
	input  logic [15:0]         timeout_ticks,
	output logic                res_valid,
	output crcdf_pkg::result_t  res
);

	crcdf_pkg::state_t state_q, state_d;
	logic        active_q, active_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [15:0] status_q, status_d;
	logic [15:0] crc_q, crc_d;
	logic [15:0] field_q, field_d;
	logic [15:0] tick_q, tick_d;

	logic [15:0] crc_next;
	logic [15:0] tick_inc;
	logic [7:0]  count_inc;
	logic [15:0] field_next;

	assign crc_next   = crcdf_pkg::crc_byte(crc_q, item.rx_byte);
	assign tick_inc   = tick_q + 16'd1;
	assign count_inc  = count_q + 8'd1;
	assign field_next = {field_q[7:0], item.rx_byte};

	always_comb begin
		state_d   = state_q;
		active_d  = active_q;
		count_d   = count_q;
		length_d  = length_q;
		opcode_d  = opcode_q;
		status_d  = status_q;
		crc_d     = crc_q;
		field_d   = field_q;
		tick_d    = tick_q;
		res_valid = 1'b0;
		res       = '0;

		if (item.req_type == crcdf_pkg::REQ_ARM) begin
			state_d  = crcdf_pkg::ST_HEADER;
			active_d = 1'b1;
			count_d  = '0;
			tick_d   = '0;
			length_d = '0;
			opcode_d = '0;
			status_d = '0;
			field_d  = '0;
			crc_d    = crcdf_pkg::CRC_INIT;
		end else if (active_q && item.req_type == crcdf_pkg::REQ_TICK) begin
			tick_d = tick_inc;
			if (tick_inc >= timeout_ticks) begin
				active_d          = 1'b0;
				res_valid         = 1'b1;
				res.out_kind      = crcdf_pkg::KIND_DONE;
				res.final_stage   = crcdf_pkg::stage_code(state_q);
				res.frame_length  = length_q;
				res.frame_opcode  = opcode_q;
				res.status_word   = status_q;
				res.received_crc  = field_q;
				res.computed_crc  = crc_q;
			end
		end else if (active_q && item.req_type == crcdf_pkg::REQ_BYTE) begin
			unique case (state_q)
				crcdf_pkg::ST_HEADER: begin
					if (item.rx_byte == crcdf_pkg::HEADER_BYTE) begin
						state_d = crcdf_pkg::ST_LENGTH;
					end
				end
				crcdf_pkg::ST_LENGTH: begin
					length_d = item.rx_byte;
					crc_d    = crc_next;
					state_d  = crcdf_pkg::ST_OPCODE;
				end
				crcdf_pkg::ST_OPCODE: begin
					opcode_d = item.rx_byte;
					crc_d    = crc_next;
					count_d  = '0;
					state_d  = crcdf_pkg::ST_STATUS;
				end
				crcdf_pkg::ST_STATUS: begin
					crc_d    = crc_next;
					status_d = {status_q[7:0], item.rx_byte};
					if (count_q == 8'd0) begin
						count_d = 8'd1;
					end else begin
						count_d = '0;
						state_d = (length_q != 8'd0) ? crcdf_pkg::ST_DATA
							: crcdf_pkg::ST_CRC;
					end
				end
				crcdf_pkg::ST_DATA: begin
					crc_d             = crc_next;
					res_valid         = 1'b1;
					res.out_kind      = crcdf_pkg::KIND_PAYLOAD;
					res.payload_byte  = item.rx_byte;
					res.payload_index = count_q;
					count_d           = count_inc;
					if (count_inc >= length_q) begin
						count_d = '0;
						state_d = crcdf_pkg::ST_CRC;
					end
				end
				crcdf_pkg::ST_CRC: begin
					field_d = field_next;
					if (count_q == 8'd0) begin
						count_d = 8'd1;
					end else begin
						count_d          = '0;
						active_d         = 1'b0;
						res_valid        = 1'b1;
						res.out_kind     = crcdf_pkg::KIND_DONE;
						res.final_stage  = crcdf_pkg::STG_CRC;
						if (field_next == crc_q) begin
							state_d         = crcdf_pkg::ST_IDLE;
							res.final_stage = crcdf_pkg::STG_GOOD;
						end
						res.frame_length = length_q;
						res.frame_opcode = opcode_q;
						res.status_word  = status_q;
						res.received_crc = field_next;
						res.computed_crc = crc_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= crcdf_pkg::ST_IDLE;
			active_q <= 1'b0;
			count_q  <= '0;
			length_q <= '0;
			opcode_q <= '0;
			status_q <= '0;
			crc_q    <= crcdf_pkg::CRC_INIT;
			field_q  <= '0;
			tick_q   <= '0;
		end else if (take) begin
			state_q  <= state_d;
			active_q <= active_d;
			count_q  <= count_d;
			length_q <= length_d;
			opcode_q <= opcode_d;
			status_q <= status_d;
			crc_q    <= crc_d;
			field_q  <= field_d;
			tick_q   <= tick_d;
		end
	end

endmodule

@@ rtl/crc16_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// crc16_packet_deframer
// Byte-serial reply deframer with a running CRC-16 check and a tick timeout.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  one request: arm, byte or tick
//  m_*       out        m_tvalid/m_tready  payload byte or frame-done report
//  APB       in/out     psel/penable       timeout_ticks at byte address 0
//
// A request is taken into an input register, processed from there by
// the frame state machine (one byte-wide CRC update and a few compares), and
// any result lands in the output register. One request per cycle is sustained
// while the output is drained; a result passes the input and output registers in turn.
// A request that produces no result moves on even while the output register
// is full, so only result-producing requests wait on m_tready.
// Reset is asynchronous and active low: the receiver comes up disarmed with
// the timeout at 500 ticks. No clearing pass is needed after reset.
module crc16_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// Input request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// Output result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_index,
	                               // [18:16] final_stage, [26:19] frame_length,
	                               // [34:27] frame_opcode, [50:35] status_word,
	                               // [66:51] received_crc, [82:67] computed_crc,
	                               // [87:83] zero
	output logic [0:0]  m_tuser,   // [0] out_kind
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0]        timeout_ticks;
	logic               valid_s1;
	crcdf_pkg::item_t   item_s1;
	logic               res_valid;
	crcdf_pkg::result_t res;
	logic               take;
	logic               valid_s2;
	crcdf_pkg::result_t res_s2;

	crcdf_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	// The held request advances when it yields nothing, or when the output
	// register is empty or being emptied in this same cycle.
	assign take     = valid_s1 && (!res_valid || !valid_s2 || m_tready);
	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.req_type <= s_tuser;
			item_s1.rx_byte  <= s_tdata;
		end
	end

	crcdf_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (item_s1),
		.take          (take),
		.timeout_ticks (timeout_ticks),
		.res_valid     (res_valid),
		.res           (res)
	);

	// Output register: loaded with a new result, or cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.out_kind;
	assign m_tdata  = {5'd0, res_s2.computed_crc, res_s2.received_crc,
		res_s2.status_word, res_s2.frame_opcode, res_s2.frame_length,
		res_s2.final_stage, res_s2.payload_index, res_s2.payload_byte};

endmodule
